// ===== hdl/pctd_pkg.sv =====
// Package for the percent-escape decoder: shared types, constants and
// hex helper functions. No dependencies.
`default_nettype none

package pctd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    // Most bytes one input transfer can produce.
    localparam int GRP_MAX = 3;

    // Group queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } pend_t;

    // The bytes produced by one input transfer, oldest in slot 0.
    typedef struct packed {
        logic [GRP_MAX-1:0][7:0] bytes;
        logic [1:0]              cnt;
        logic                    fin;
    } group_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Value of a byte already known to be a hex digit.
    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        if (c <= 8'h39)
        begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pctd_front.sv =====
// Front part of the percent-escape decoder: escape state and classification
// of each input byte into a group of output bytes. Depends on pctd_pkg.
`default_nettype none

module pctd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      in_byte,
    input  wire logic            is_final,
    input  wire logic            fifo_full,
    output logic                 push,
    output pctd_pkg::group_t     push_grp
);
    import pctd_pkg::*;

    pend_t      pend_reg, pend_next;
    logic [7:0] held_reg, held_next;
    logic       accept;
    logic [1:0] n;
    group_t     grp;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (grp.cnt != 2'd0);
    assign push_grp = grp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
            held_reg <= 8'h00;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            held_reg <= held_next;
        end
    end

    always_comb
    begin
        pend_next = PEND_NONE;
        held_next = 8'h00;
        n         = 2'd0;
        grp       = '0;
        grp.fin   = is_final;

        unique case (pend_reg)
            PEND_PCT:
            begin
                if (is_hex(in_byte))
                begin
                    held_next = in_byte;
                    pend_next = PEND_DIGIT;
                end
                else
                begin
                    grp.bytes[n] = PCT_CHAR;
                    n = n + 2'd1;
                    if (in_byte == PCT_CHAR)
                    begin
                        pend_next = PEND_PCT;
                    end
                    else
                    begin
                        grp.bytes[n] = in_byte;
                        n = n + 2'd1;
                    end
                end
            end
            PEND_DIGIT:
            begin
                // The held byte is always a hex digit here.
                if (is_hex(in_byte) && ({hex_nib(held_reg), hex_nib(in_byte)} != 8'h00))
                begin
                    grp.bytes[n] = {hex_nib(held_reg), hex_nib(in_byte)};
                    n = n + 2'd1;
                end
                else
                begin
                    grp.bytes[n] = PCT_CHAR;
                    n = n + 2'd1;
                    grp.bytes[n] = held_reg;
                    n = n + 2'd1;
                    if (in_byte == PCT_CHAR)
                    begin
                        pend_next = PEND_PCT;
                    end
                    else
                    begin
                        grp.bytes[n] = in_byte;
                        n = n + 2'd1;
                    end
                end
            end
            default:
            begin
                if (in_byte == PCT_CHAR)
                begin
                    pend_next = PEND_PCT;
                end
                else
                begin
                    grp.bytes[n] = in_byte;
                    n = n + 2'd1;
                end
            end
        endcase

        // End of string: whatever escape is still open goes out literally.
        if (is_final)
        begin
            if (pend_next == PEND_PCT)
            begin
                grp.bytes[n] = PCT_CHAR;
                n = n + 2'd1;
            end
            else if (pend_next == PEND_DIGIT)
            begin
                grp.bytes[n] = PCT_CHAR;
                n = n + 2'd1;
                grp.bytes[n] = held_next;
                n = n + 2'd1;
            end
            pend_next = PEND_NONE;
            held_next = 8'h00;
        end

        grp.cnt = n;
    end

endmodule

`default_nettype wire

// ===== hdl/pctd_fifo.sv =====
// Short queue of byte groups between the front and back parts of the
// percent-escape decoder. Depends on pctd_pkg.
`default_nettype none

module pctd_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire pctd_pkg::group_t  push_grp,
    input  wire logic              pop,
    output pctd_pkg::group_t       head,
    output logic                   full,
    output logic                   empty
);
    import pctd_pkg::*;

    group_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg, count_next;

    assign full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_grp;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pctd_back.sv =====
// Back part of the percent-escape decoder: unpacks queued groups into one output
// byte per cycle while out_ready allows, via an output register. Needs pctd_pkg.
`default_nettype none

module pctd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pctd_pkg::group_t  head,
    input  wire logic              fifo_empty,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   run_last,
    output logic                   string_end
);
    import pctd_pkg::*;

    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    group_t     grp_reg, grp_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       run_last_reg, run_last_next;
    logic       string_end_reg, string_end_next;

    group_t     src;
    logic [1:0] src_idx;
    logic       load, take, last;

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign string_end = string_end_reg;

    always_comb
    begin
        load     = !out_valid_reg || out_ready;
        src      = busy_reg ? grp_reg : head;
        src_idx  = busy_reg ? idx_reg : 2'd0;
        take     = load && (busy_reg || !fifo_empty);
        last     = (src_idx == (src.cnt - 2'd1));
        pop      = take && !busy_reg;

        busy_next       = busy_reg;
        idx_next        = idx_reg;
        grp_next        = grp_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        run_last_next   = run_last_reg;
        string_end_next = string_end_reg;

        if (take)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = src.bytes[src_idx];
            run_last_next   = last;
            string_end_next = last && src.fin;
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
                idx_next  = src_idx + 2'd1;
                grp_next  = src;
            end
        end
        else if (load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        grp_reg        <= grp_next;
        out_byte_reg   <= out_byte_next;
        run_last_reg   <= run_last_next;
        string_end_reg <= string_end_next;
    end

endmodule

`default_nettype wire

// ===== hdl/percent_escape_decoder_top.sv =====
// Top level of the percent-escape (URL) decoder: front, group queue and back.
// Depends on pctd_pkg, pctd_front, pctd_fifo and pctd_back.
`default_nettype none

// Channel  Handshake            Payload                          Direction
// -------  -------------------  -------------------------------  ---------
// input    in_valid / in_ready  in_byte[7:0], is_final           into block
// output   out_valid/out_ready  out_byte[7:0], run_last,         out of block
//                               string_end
//
// Flow: one input transfer is taken every cycle while the group queue has
// room; each output byte leaves on its own cycle, so the rate is set by the
// back part's one-byte-per-cycle unpacker and by out_ready. An input byte
// passes through the queue entry written at its transfer and then through
// the output register before it reaches the output.
// Reset: rst_n clears the escape state, the queue pointers and the output
// valid; no clearing pass is needed.
// Stalls: the input side stalls only when the four-entry queue is full, and
// the output side never blocks the front while queue space remains.
//
// The front part holds the escape state (pending count and first digit) and
// turns each input byte into a group of zero to three output bytes. Groups
// with no bytes (an escape still open) are not queued. The back part pops a
// group and sends its bytes in order, marking the last byte of each group
// with run_last and, for a group that ends a string, with string_end.

module percent_escape_decoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       is_final,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            string_end
);
    import pctd_pkg::*;

    logic   push;
    group_t push_grp;
    logic   pop;
    group_t head;
    logic   fifo_full;
    logic   fifo_empty;

    pctd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .is_final  (is_final),
        .fifo_full (fifo_full),
        .push      (push),
        .push_grp  (push_grp)
    );

    pctd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .head     (head),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    pctd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

    // A queued group always carries at least one byte, and a final one too.
    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_grp.cnt != 2'd0))
        else $error("empty group queued");

    // The back part only pops a group the queue actually holds.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_empty)
        else $error("pop from empty group queue");

    // The end of a string is always the last byte of its input transfer.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && string_end) |-> run_last)
        else $error("string_end without run_last");

    // A final input transfer always produces a group marked final.
    a_final_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && is_final) |-> (push && push_grp.fin))
        else $error("final byte produced no final group");

endmodule

`default_nettype wire
